// ----- src/hrsp_pkg.sv -----
package hrsp_pkg;

    localparam int LENGTH_BITS = 20;
    localparam int CODE_BITS   = 10;
    localparam int KEY_LEN     = 14;
    localparam int KEY_POS_W   = 4;

    localparam logic [CODE_BITS-1:0]   CODE_MAX   = CODE_BITS'(999);
    localparam logic [CODE_BITS-1:0]   CODE_OK    = CODE_BITS'(200);
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;

    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_REASON = 3'd1;
    localparam logic [2:0] K_BODY   = 3'd2;
    localparam logic [2:0] K_OK     = 3'd3;
    localparam logic [2:0] K_HTTP   = 3'd4;
    localparam logic [2:0] K_PARSE  = 3'd5;

    typedef enum logic [3:0] {
        P_VERSION   = 4'd0,
        P_CODE      = 4'd1,
        P_REASON    = 4'd2,
        P_STATUS_LF = 4'd3,
        P_KEY       = 4'd4,
        P_VALUE     = 4'd5,
        P_HDR_LF    = 4'd6,
        P_LINE      = 4'd7,
        P_END_LF    = 4'd8,
        P_BODY      = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        V_SPACES = 2'd0,
        V_DIGITS = 2'd1,
        V_DONE   = 2'd2
    } t_vphase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_closed;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]             result_kind;
        logic [7:0]             out_byte;
        logic [CODE_BITS-1:0]   status_code;
        logic [LENGTH_BITS-1:0] content_length;
        logic                   last;
    } t_out_beat;

    function automatic logic [7:0] key_char(input logic [KEY_POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h6e;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6e;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2d;
            4'd8:    c = 8'h6c;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6e;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- src/http_response_stream_parser.sv -----
// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_stall     | i_in_beat  (data_byte, stream_closed)
// out     | output    | o_out_valid / i_out_stall   | o_out_beat (kind, byte, code, length, last)
//
// one beat in per cycle while o_in_stall is low, one result beat out per input beat
// path: input register, then parse logic into a two-entry result buffer
// synchronous active-low reset returns the parser to the version text, buffers empty
// o_in_stall comes from registers only; it rises when the result buffer is full
// and a beat waits in the input register
module http_response_stream_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hrsp_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hrsp_pkg::t_out_beat o_out_beat
);
    import hrsp_pkg::*;

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      w_space;
    logic      w_adv;
    logic      w_take;
    t_out_beat w_res;

    assign o_in_stall = r_in_valid && !w_space;
    assign w_take     = i_in_valid && !o_in_stall;
    assign w_adv      = r_in_valid && w_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_beat <= i_in_beat;
        end
    end

    hrsp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_beat  (r_in_beat),
        .o_res   (w_res)
    );

    hrsp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_adv),
        .i_beat  (w_res),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_beat)
    );

endmodule

// ----- src/hrsp_step.sv -----
module hrsp_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  hrsp_pkg::t_in_beat  i_beat,
    output hrsp_pkg::t_out_beat o_res
);
    import hrsp_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [CODE_BITS-1:0]   r_code_acc, n_code_acc;
    logic                   r_reason_seen, n_reason_seen;
    logic [KEY_POS_W-1:0]   r_key_pos, n_key_pos;
    logic                   r_key_mis, n_key_mis;
    logic                   r_key_started, n_key_started;
    t_vphase                r_vphase, n_vphase;
    logic [LENGTH_BITS-1:0] r_length_acc, n_length_acc;
    logic [LENGTH_BITS-1:0] r_bytes_left, n_bytes_left;

    logic [7:0]             w_b;
    logic                   w_digit_ok;
    logic [3:0]             w_digit;
    logic [CODE_BITS+3:0]   w_code_mul;
    logic [LENGTH_BITS+3:0] w_len_mul;
    logic                   w_key_hit;
    logic [KEY_POS_W-1:0]   w_kb_pos;
    logic                   w_kb_mis;
    logic                   w_kb_started;
    logic [2:0]             w_kind;
    logic [2:0]             w_status_err;
    logic [7:0]             w_byte;
    logic                   w_last;

    // case folding and small helpers
    always_comb begin
        w_b = i_beat.data_byte;
        if (i_beat.data_byte inside {[CH_UA:CH_UZ]}) begin
            w_b = i_beat.data_byte | 8'h20;
        end
        w_digit_ok   = (w_b inside {[CH_ZERO:CH_NINE]});
        w_digit      = 4'(w_b - CH_ZERO);
        w_code_mul   = (CODE_BITS+4)'(r_code_acc) * (CODE_BITS+4)'(10)
                     + (CODE_BITS+4)'(w_digit);
        w_len_mul    = (LENGTH_BITS+4)'(r_length_acc) * (LENGTH_BITS+4)'(10)
                     + (LENGTH_BITS+4)'(w_digit);
        w_key_hit    = !r_key_mis && (r_key_pos == KEY_POS_W'(KEY_LEN));
        w_status_err = r_reason_seen ? K_HTTP : K_PARSE;
    end

    // key byte matching against the content-length name
    always_comb begin
        w_kb_pos     = r_key_pos;
        w_kb_mis     = r_key_mis;
        w_kb_started = r_key_started;
        if (!(w_b == CH_SPACE && !r_key_started)) begin
            w_kb_started = 1'b1;
            if (r_key_pos < KEY_POS_W'(KEY_LEN) && w_b == key_char(r_key_pos)) begin
                w_kb_pos = r_key_pos + 1'b1;
            end else begin
                w_kb_mis = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_code_acc    = r_code_acc;
        n_reason_seen = r_reason_seen;
        n_key_pos     = r_key_pos;
        n_key_mis     = r_key_mis;
        n_key_started = r_key_started;
        n_vphase      = r_vphase;
        n_length_acc  = r_length_acc;
        n_bytes_left  = r_bytes_left;
        if (!i_beat.stream_closed) begin
            case (r_phase)
                P_VERSION: begin
                    if (w_b == CH_SPACE) n_phase = P_CODE;
                end
                P_CODE: begin
                    if (w_digit_ok) begin
                        n_code_acc = (w_code_mul > (CODE_BITS+4)'(CODE_MAX)) ?
                                     CODE_MAX : CODE_BITS'(w_code_mul);
                    end else if (w_b == CH_SPACE) begin
                        n_phase = P_REASON;
                    end
                end
                P_REASON: begin
                    if (w_b == CH_CR) begin
                        n_phase = P_STATUS_LF;
                    end else begin
                        n_reason_seen = 1'b1;
                    end
                end
                P_STATUS_LF: begin
                    if (w_b == CH_LF && r_code_acc == CODE_OK) begin
                        n_phase       = P_KEY;
                        n_key_pos     = '0;
                        n_key_mis     = 1'b0;
                        n_key_started = 1'b0;
                        n_vphase      = V_SPACES;
                    end
                end
                P_KEY: begin
                    if (w_b == CH_COLON) begin
                        n_phase  = P_VALUE;
                        n_vphase = V_SPACES;
                        if (w_key_hit) n_length_acc = '0;
                    end else begin
                        n_key_pos     = w_kb_pos;
                        n_key_mis     = w_kb_mis;
                        n_key_started = w_kb_started;
                    end
                end
                P_VALUE: begin
                    if (w_b == CH_CR) begin
                        n_phase = P_HDR_LF;
                    end else if (w_key_hit) begin
                        if (r_vphase == V_SPACES && w_b == CH_SPACE) begin
                            n_vphase = V_SPACES;
                        end else if (r_vphase != V_DONE && w_digit_ok) begin
                            n_length_acc = (w_len_mul > (LENGTH_BITS+4)'(LENGTH_MAX)) ?
                                           LENGTH_MAX : LENGTH_BITS'(w_len_mul);
                            n_vphase     = V_DIGITS;
                        end else begin
                            n_vphase = V_DONE;
                        end
                    end
                end
                P_HDR_LF: begin
                    if (w_b == CH_LF) begin
                        n_phase       = P_LINE;
                        n_key_pos     = '0;
                        n_key_mis     = 1'b0;
                        n_key_started = 1'b0;
                        n_vphase      = V_SPACES;
                    end
                end
                P_LINE: begin
                    if (w_b inside {[CH_LA:CH_LZ]}) begin
                        n_phase       = P_KEY;
                        n_key_pos     = w_kb_pos;
                        n_key_mis     = w_kb_mis;
                        n_key_started = w_kb_started;
                    end else if (w_b == CH_CR) begin
                        n_phase = P_END_LF;
                    end
                end
                P_END_LF: begin
                    if (w_b == CH_LF) begin
                        n_bytes_left = r_length_acc;
                        if (r_length_acc != '0) n_phase = P_BODY;
                    end
                end
                P_BODY: begin
                    if (r_bytes_left != '0) n_bytes_left = r_bytes_left - 1'b1;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // result outputs
    always_comb begin
        w_kind = K_NONE;
        w_byte = '0;
        w_last = 1'b0;
        if (i_beat.stream_closed) begin
            w_last = 1'b1;
            if (r_phase == P_BODY) begin
                w_kind = K_OK;
            end else if (r_phase inside {P_VERSION, P_CODE, P_REASON, P_STATUS_LF}) begin
                w_kind = w_status_err;
            end else begin
                w_kind = K_PARSE;
            end
        end else begin
            case (r_phase)
                P_VERSION: w_kind = K_NONE;
                P_CODE: begin
                    if (!w_digit_ok && w_b != CH_SPACE) begin
                        w_kind = K_PARSE;
                        w_last = 1'b1;
                    end
                end
                P_REASON: begin
                    if (w_b != CH_CR) begin
                        w_kind = K_REASON;
                        w_byte = w_b;
                    end
                end
                P_STATUS_LF: begin
                    if (!(w_b == CH_LF && r_code_acc == CODE_OK)) begin
                        w_kind = w_status_err;
                        w_last = 1'b1;
                    end
                end
                P_KEY, P_VALUE: w_kind = K_NONE;
                P_HDR_LF: begin
                    if (w_b != CH_LF) begin
                        w_kind = K_PARSE;
                        w_last = 1'b1;
                    end
                end
                P_LINE: begin
                    if (!(w_b inside {[CH_LA:CH_LZ]}) && w_b != CH_CR) begin
                        w_kind = K_PARSE;
                        w_last = 1'b1;
                    end
                end
                P_END_LF: begin
                    if (w_b == CH_LF) begin
                        w_kind = K_OK;
                        w_last = (r_length_acc == '0);
                    end else begin
                        w_kind = K_PARSE;
                        w_last = 1'b1;
                    end
                end
                P_BODY: begin
                    w_kind = K_BODY;
                    w_byte = i_beat.data_byte;
                    w_last = (n_bytes_left == '0);
                end
                default: begin
                    w_kind = K_PARSE;
                    w_last = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_res.result_kind    = w_kind;
        o_res.out_byte       = w_byte;
        o_res.status_code    = n_code_acc;
        o_res.content_length = (w_kind == K_HTTP || w_kind == K_PARSE) ? '0 : n_length_acc;
        o_res.last           = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= P_VERSION;
            r_code_acc    <= '0;
            r_reason_seen <= 1'b0;
            r_key_pos     <= '0;
            r_key_mis     <= 1'b0;
            r_key_started <= 1'b0;
            r_vphase      <= V_SPACES;
            r_length_acc  <= '0;
            r_bytes_left  <= '0;
        end else if (i_en) begin
            if (w_last) begin
                // response finished, back to the start of a new one
                r_phase       <= P_VERSION;
                r_code_acc    <= '0;
                r_reason_seen <= 1'b0;
                r_key_pos     <= '0;
                r_key_mis     <= 1'b0;
                r_key_started <= 1'b0;
                r_vphase      <= V_SPACES;
                r_length_acc  <= '0;
                r_bytes_left  <= '0;
            end else begin
                r_phase       <= n_phase;
                r_code_acc    <= n_code_acc;
                r_reason_seen <= n_reason_seen;
                r_key_pos     <= n_key_pos;
                r_key_mis     <= n_key_mis;
                r_key_started <= n_key_started;
                r_vphase      <= n_vphase;
                r_length_acc  <= n_length_acc;
                r_bytes_left  <= n_bytes_left;
            end
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_last |=> r_phase == P_VERSION && r_code_acc == '0 && r_length_acc == '0)
        else $error("state not cleared after last result");

    a_body_only_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_kind == K_BODY |-> r_phase == P_BODY && r_bytes_left != '0)
        else $error("body beat outside body phase");

    a_reason_marks_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_kind == K_REASON |=> r_reason_seen)
        else $error("reason byte not recorded");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_kind == K_HTTP || w_kind == K_PARSE) |-> w_last && o_res.content_length == '0)
        else $error("error result not final or carries a length");

endmodule

// ----- src/hrsp_out_buf.sv -----
module hrsp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hrsp_pkg::t_out_beat i_beat,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_stall,
    output hrsp_pkg::t_out_beat o_beat
);
    import hrsp_pkg::*;

    t_out_beat  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_beat  = r_mem[r_rd_ptr];
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2))
        else $error("push into full result buffer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_ptr_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("buffer pointers disagree with count");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import hrsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [8*KEY_LEN-1:0] LEN_KEY = "content-length";

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_beat = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_beat;

    logic        idle_on = 1'b0;
    logic        hold_on = 1'b0;
    int          stall_left = 0;
    int          sent_cnt = 0;
    int          err_cnt = 0;
    int unsigned cycle_cnt = 0;

    // parser copy
    t_phase                 ph = P_VERSION;
    logic [CODE_BITS-1:0]   code_q = '0;
    logic                   reason_q = 1'b0;
    logic [KEY_POS_W-1:0]   key_pos_q = '0;
    logic                   key_bad_q = 1'b0;
    logic                   key_started_q = 1'b0;
    t_vphase                vph_q = V_SPACES;
    logic [LENGTH_BITS-1:0] len_q = '0;
    logic [LENGTH_BITS-1:0] left_q = '0;

    t_out_beat  exp_results[$];
    t_out_beat  want_beat;
    logic [7:0] stream_q[$];
    logic       need_close;

    http_response_stream_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (idle_on && stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            stall_left <= 0;
            i_out_stall <= hold_on;
        end
    end

    function automatic logic [7:0] length_key_char(input int pos);
        return LEN_KEY[8*(KEY_LEN-1-pos) +: 8];
    endfunction

    function automatic logic [7:0] pick_byte_except(input logic [7:0] avoid);
        logic [7:0] c;
        c = 8'($urandom);
        if (c == avoid) c = c ^ 8'h01;
        return c;
    endfunction

    function automatic logic key_hit();
        return !key_bad_q && key_pos_q == KEY_POS_W'(KEY_LEN);
    endfunction

    task automatic clear_key();
        key_pos_q = '0;
        key_bad_q = 1'b0;
        key_started_q = 1'b0;
        vph_q = V_SPACES;
    endtask

    task automatic clear_parser();
        ph = P_VERSION;
        code_q = '0;
        reason_q = 1'b0;
        clear_key();
        len_q = '0;
        left_q = '0;
    endtask

    task automatic push_result(input logic [2:0] kind, input logic [7:0] b, input logic last);
        t_out_beat r;
        r.result_kind = kind;
        r.out_byte = (kind == K_REASON || kind == K_BODY) ? b : 8'h00;
        r.status_code = code_q;
        r.content_length = (kind == K_HTTP || kind == K_PARSE) ? '0 : len_q;
        r.last = last;
        exp_results.push_back(r);
        if (last) clear_parser();
    endtask

    task automatic key_text_byte(input logic [7:0] b);
        if (b == CH_SPACE && !key_started_q) return;
        key_started_q = 1'b1;
        if (key_pos_q < KEY_LEN && b == length_key_char(key_pos_q))
            key_pos_q = key_pos_q + 1'b1;
        else
            key_bad_q = 1'b1;
    endtask

    task automatic predict_beat(input t_in_beat beat);
        logic [7:0]  raw;
        logic [7:0]  b;
        logic [2:0]  status_err;
        logic        digit;
        logic [31:0] code_next;
        logic [63:0] len_next;
        raw = beat.data_byte;
        b = (raw >= CH_UA && raw <= CH_UZ) ? raw + 8'h20 : raw;
        status_err = reason_q ? K_HTTP : K_PARSE;
        digit = b >= CH_ZERO && b <= CH_NINE;
        code_next = 32'(code_q) * 32'd10 + 32'(b - CH_ZERO);
        len_next = 64'(len_q) * 64'd10 + 64'(b - CH_ZERO);
        if (beat.stream_closed) begin
            if (ph == P_BODY) push_result(K_OK, 8'h00, 1'b1);
            else if (ph >= P_KEY) push_result(K_PARSE, 8'h00, 1'b1);
            else push_result(status_err, 8'h00, 1'b1);
        end else begin
            case (ph)
                P_VERSION: begin
                    if (b == CH_SPACE) ph = P_CODE;
                    push_result(K_NONE, 8'h00, 1'b0);
                end
                P_CODE: begin
                    if (digit) begin
                        code_q = (code_next > 32'(CODE_MAX)) ? CODE_MAX : code_next[CODE_BITS-1:0];
                        push_result(K_NONE, 8'h00, 1'b0);
                    end else if (b == CH_SPACE) begin
                        ph = P_REASON;
                        push_result(K_NONE, 8'h00, 1'b0);
                    end else begin
                        push_result(K_PARSE, 8'h00, 1'b1);
                    end
                end
                P_REASON: begin
                    if (b == CH_CR) begin
                        ph = P_STATUS_LF;
                        push_result(K_NONE, 8'h00, 1'b0);
                    end else begin
                        reason_q = 1'b1;
                        push_result(K_REASON, b, 1'b0);
                    end
                end
                P_STATUS_LF: begin
                    if (b == CH_LF && code_q == CODE_OK) begin
                        ph = P_KEY;
                        clear_key();
                        push_result(K_NONE, 8'h00, 1'b0);
                    end else begin
                        push_result(status_err, 8'h00, 1'b1);
                    end
                end
                P_KEY: begin
                    if (b == CH_COLON) begin
                        ph = P_VALUE;
                        vph_q = V_SPACES;
                        if (key_hit()) len_q = '0;
                    end else begin
                        key_text_byte(b);
                    end
                    push_result(K_NONE, 8'h00, 1'b0);
                end
                P_VALUE: begin
                    if (b == CH_CR) begin
                        ph = P_HDR_LF;
                    end else if (key_hit()) begin
                        if (vph_q == V_SPACES && b == CH_SPACE) begin
                            // trimmed
                        end else if (vph_q != V_DONE && digit) begin
                            len_q = (len_next > 64'(LENGTH_MAX)) ? LENGTH_MAX
                                                                 : len_next[LENGTH_BITS-1:0];
                            vph_q = V_DIGITS;
                        end else begin
                            vph_q = V_DONE;
                        end
                    end
                    push_result(K_NONE, 8'h00, 1'b0);
                end
                P_HDR_LF: begin
                    if (b == CH_LF) begin
                        ph = P_LINE;
                        clear_key();
                        push_result(K_NONE, 8'h00, 1'b0);
                    end else begin
                        push_result(K_PARSE, 8'h00, 1'b1);
                    end
                end
                P_LINE: begin
                    if (b >= CH_LA && b <= CH_LZ) begin
                        ph = P_KEY;
                        key_text_byte(b);
                        push_result(K_NONE, 8'h00, 1'b0);
                    end else if (b == CH_CR) begin
                        ph = P_END_LF;
                        push_result(K_NONE, 8'h00, 1'b0);
                    end else begin
                        push_result(K_PARSE, 8'h00, 1'b1);
                    end
                end
                P_END_LF: begin
                    if (b == CH_LF) begin
                        left_q = len_q;
                        if (left_q == '0) begin
                            push_result(K_OK, 8'h00, 1'b1);
                        end else begin
                            ph = P_BODY;
                            push_result(K_OK, 8'h00, 1'b0);
                        end
                    end else begin
                        push_result(K_PARSE, 8'h00, 1'b1);
                    end
                end
                P_BODY: begin
                    if (left_q != '0) left_q = left_q - 1'b1;
                    push_result(K_BODY, raw, left_q == '0);
                end
                default: push_result(K_PARSE, 8'h00, 1'b1);
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < 200) $display("tb: mismatch %s got %0d want %0d", what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) predict_beat(i_in_beat);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_results.size() == 0) begin
                report_mismatch("beat with nothing pending, kind", o_out_beat.result_kind, 0);
            end else begin
                want_beat = exp_results.pop_front();
                if (o_out_beat.result_kind !== want_beat.result_kind)
                    report_mismatch("result_kind", o_out_beat.result_kind, want_beat.result_kind);
                if (o_out_beat.out_byte !== want_beat.out_byte)
                    report_mismatch("out_byte", o_out_beat.out_byte, want_beat.out_byte);
                if (o_out_beat.status_code !== want_beat.status_code)
                    report_mismatch("status_code", o_out_beat.status_code, want_beat.status_code);
                if (o_out_beat.content_length !== want_beat.content_length)
                    report_mismatch("content_length", o_out_beat.content_length,
                                    want_beat.content_length);
                if (o_out_beat.last !== want_beat.last)
                    report_mismatch("last", o_out_beat.last, want_beat.last);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic closed);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= '{data_byte: b, stream_closed: closed};
        do @(posedge i_clk); while (o_in_stall);
        sent_cnt++;
    endtask

    task automatic send_stream(input logic close_end);
        foreach (stream_q[i]) send_beat(stream_q[i], 1'b0);
        if (close_end) send_beat(8'($urandom), 1'b1);
    endtask

    task automatic make_response();
        int         n_hdr;
        int         mode;
        int         nd;
        int         klen;
        int         k;
        logic [63:0] val;
        logic [63:0] len;
        logic       matched;
        logic       junk_first;
        logic [7:0] c;
        stream_q.delete();
        need_close = 1'b0;
        len = 0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) stream_q.push_back(8'($urandom));
            need_close = 1'b1;
            return;
        end
        repeat ($urandom_range(0, 3)) stream_q.push_back(pick_byte_except(CH_SPACE));
        stream_q.push_back(CH_SPACE);
        if ($urandom_range(0, 9) < 8) begin
            stream_q.push_back("2");
            stream_q.push_back("0");
            stream_q.push_back("0");
        end else begin
            repeat ($urandom_range(0, 5)) stream_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            need_close = 1'b1;
        end
        stream_q.push_back(CH_SPACE);
        repeat ($urandom_range(0, 4)) stream_q.push_back(pick_byte_except(CH_CR));
        stream_q.push_back(CH_CR);
        stream_q.push_back(CH_LF);
        if (need_close) return;
        n_hdr = $urandom_range(0, 3);
        for (int h = 0; h < n_hdr; h++) begin
            if (h == 0) repeat ($urandom_range(0, 2)) stream_q.push_back(CH_SPACE);
            mode = $urandom_range(0, 3);
            matched = (mode < 2);
            if (mode < 2) begin
                for (k = 0; k < KEY_LEN; k++) begin
                    c = length_key_char(k);
                    if (c >= CH_LA && $urandom_range(0, 1) == 1) c = c - 8'h20;
                    stream_q.push_back(c);
                end
            end else if (mode == 2) begin
                repeat ($urandom_range(1, 6)) stream_q.push_back(CH_LA + 8'($urandom_range(0, 25)));
            end else begin
                // near miss: short prefix or one letter too many
                klen = $urandom_range(1, KEY_LEN);
                for (k = 0; k < klen; k++) stream_q.push_back(length_key_char(k));
                if (klen == KEY_LEN) stream_q.push_back("s");
            end
            stream_q.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) stream_q.push_back(CH_SPACE);
            junk_first = ($urandom_range(0, 5) == 0);
            if (junk_first) stream_q.push_back("x");
            k = $urandom_range(0, 7);
            nd = (k == 0) ? 7 : (k < 5) ? 1 : (k < 7) ? 0 : 2;
            val = 0;
            repeat (nd) begin
                c = CH_ZERO + 8'($urandom_range(0, 9));
                stream_q.push_back(c);
                val = val * 10 + 64'(c - CH_ZERO);
                if (val > 64'(LENGTH_MAX)) val = 64'(LENGTH_MAX);
            end
            if ($urandom_range(0, 3) == 0) stream_q.push_back("z");
            if (matched) len = junk_first ? 64'd0 : val;
            stream_q.push_back(CH_CR);
            stream_q.push_back(CH_LF);
        end
        stream_q.push_back(CH_CR);
        stream_q.push_back(CH_LF);
        if (len <= 12) begin
            repeat (len) stream_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 5)) stream_q.push_back(8'($urandom));
            need_close = 1'b1;
        end
        if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(0, stream_q.size() - 1);
            if ($urandom_range(0, 1) == 1) stream_q[k] = 8'($urandom);
            else stream_q = stream_q[0:k];
            need_close = 1'b1;
        end
    endtask

    task automatic test_status_line();
        idle_on <= 1'b0;
        stream_q.delete();
        send_stream(1'b1);
        stream_q = '{8'hff, 8'h00, CH_SPACE, "2", "a"};
        send_stream(1'b0);
        stream_q = '{CH_SPACE, "9", "9", "9", "9", CH_SPACE, "E", CH_CR, CH_LF};
        send_stream(1'b0);
        stream_q = '{CH_SPACE, CH_SPACE, CH_CR, 8'h00};
        send_stream(1'b0);
        stream_q = '{CH_SPACE, "2", "0", "0", CH_SPACE, CH_CR, CH_LF, CH_CR, CH_LF};
        send_stream(1'b0);
    endtask

    task automatic test_backpressure();
        idle_on <= 1'b0;
        fork
            begin
                hold_on <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_on <= 1'b0;
            end
            repeat (2) begin
                make_response();
                send_stream(need_close);
            end
        join
    endtask

    task automatic test_random_responses();
        idle_on <= 1'b1;
        while (sent_cnt < 880) begin
            make_response();
            send_stream(need_close);
        end
    endtask

    task automatic test_back_to_back();
        idle_on <= 1'b0;
        repeat (3) begin
            make_response();
            send_stream(need_close);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_status_line();
        test_backpressure();
        test_random_responses();
        test_back_to_back();
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- http_response_stream_parser.f -----
src/hrsp_pkg.sv
src/hrsp_step.sv
src/hrsp_out_buf.sv
src/http_response_stream_parser.sv
sim/tb.sv
